// File: sv/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types, codes and constants for the audio jitter buffer with
// sequence tracking.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int MAX_TARGET_DEF  = 32;
  localparam int STORE_DEPTH_DEF = 64;

  localparam int ACTION_W  = 2;
  localparam int SEQ_W     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int KIND_W    = 3;
  localparam int GAP_W     = 10;
  localparam int DROP_W    = 7;
  localparam int COUNT_W   = 32;
  localparam int BUF_W     = 7;
  localparam int TARGET_W  = 6;
  localparam int PHASE_W   = 8;

  localparam int GAP_LIMIT    = 1000;
  localparam int STATS_PERIOD = 250;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(4);

  localparam logic [ACTION_W-1:0] ACT_ARRIVAL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_QUEUED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOT_PRIMED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNDERRUN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SAMPLES    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESTARTED  = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture an input item
    logic exec;    // execute the captured item
    logic cfg_we;  // write the target register
  } ajb_cmd_t;

endpackage

// File: sv/ajb_ctrl.sv
// ----------------------------------------------------------------------------
// ajb_ctrl
// Two-state sequencer: accept an item, then execute it in the datapath.
// ----------------------------------------------------------------------------
module ajb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            cfg_valid,
  output logic            busy,
  output logic            cfg_ready,
  output ajb_pkg::ajb_cmd_t cmd
);
  import ajb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r == ST_EXEC);
  assign cfg_ready  = !busy;
  assign cmd.load   = start && !busy;
  assign cmd.exec   = busy;
  assign cmd.cfg_we = cfg_valid && !busy;

endmodule

// File: sv/ajb_datapath.sv
// ----------------------------------------------------------------------------
// ajb_datapath
// Packet ring, sequence/loss tracking, counters and the result register.
// ----------------------------------------------------------------------------
module ajb_datapath #(
  parameter int MAX_TARGET  = ajb_pkg::MAX_TARGET_DEF,
  parameter int STORE_DEPTH = ajb_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ajb_pkg::ajb_cmd_t             cmd,
  input  logic [ajb_pkg::TARGET_W-1:0]  cfg_target_depth,
  input  logic [ajb_pkg::ACTION_W-1:0]  in_action,
  input  logic [ajb_pkg::SEQ_W-1:0]     in_seq_num,
  input  logic [ajb_pkg::PAYLOAD_W-1:0] in_payload_handle,
  output logic                          out_valid,
  output logic [ajb_pkg::KIND_W-1:0]    out_kind,
  output logic [ajb_pkg::SEQ_W-1:0]     out_seq,
  output logic [ajb_pkg::PAYLOAD_W-1:0] out_payload,
  output logic [ajb_pkg::GAP_W-1:0]     out_gap,
  output logic                          out_gap_reported,
  output logic [ajb_pkg::DROP_W-1:0]    out_dropped,
  output logic                          out_stats_due,
  output logic [ajb_pkg::COUNT_W-1:0]   out_packets_received,
  output logic [ajb_pkg::COUNT_W-1:0]   out_packets_lost,
  output logic [ajb_pkg::BUF_W-1:0]     out_buffered,
  output logic                          out_primed
);
  import ajb_pkg::*;

  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int OCC_W   = $clog2(STORE_DEPTH + 1);
  localparam int LIM_W   = $clog2(2 * MAX_TARGET + 1);
  localparam int CW0     = (OCC_W > LIM_W) ? OCC_W : LIM_W;
  localparam int CW      = ((CW0 > TARGET_W) ? CW0 : TARGET_W) + 1;
  localparam int ENTRY_W = SEQ_W + PAYLOAD_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] MAXT_C  = CW'(MAX_TARGET);

  // ring storage
  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  // captured item
  logic [ACTION_W-1:0]  act_r;
  logic [SEQ_W-1:0]     seq_r;
  logic [PAYLOAD_W-1:0] pay_r;

  // tracker state
  logic [TARGET_W-1:0] target_r;
  logic [IDX_W-1:0]    head_r,  head_nxt;
  logic [OCC_W-1:0]    occ_r,   occ_nxt;
  logic                primed_r, primed_nxt;
  logic                first_r,  first_nxt;
  logic [SEQ_W-1:0]    last_r,   last_nxt;
  logic [COUNT_W-1:0]  rcv_r,    rcv_nxt;
  logic [COUNT_W-1:0]  lost_r,   lost_nxt;
  logic [PHASE_W-1:0]  phase_r,  phase_nxt;

  // result fields
  logic                 valid_r,  valid_nxt;
  logic [KIND_W-1:0]    kind_r,   kind_nxt;
  logic [SEQ_W-1:0]     oseq_r,   oseq_nxt;
  logic [PAYLOAD_W-1:0] opay_r,   opay_nxt;
  logic [GAP_W-1:0]     gap_r,    gap_nxt;
  logic                 grep_r,   grep_nxt;
  logic [DROP_W-1:0]    drop_r,   drop_nxt;
  logic                 stats_r,  stats_nxt;

  // arrival arithmetic
  logic [CW-1:0]    tgt, limit, occ_x, occ1, occ2, extra, sum_a, sum_b, sum_c;
  logic             full;
  logic [IDX_W-1:0] head1;
  logic [SEQ_W-1:0] expect_seq, diff;
  logic [PHASE_W:0] phase_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {seq_r, pay_r};
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      seq_r <= in_seq_num;
      pay_r <= in_payload_handle;
    end
  end

  always_comb begin
    // clamp the target into 1..MAX_TARGET, limit at min(2*target, depth)
    tgt = CW'(target_r);
    if (tgt == '0) begin
      tgt = CW'(1);
    end
    if (tgt > MAXT_C) begin
      tgt = MAXT_C;
    end
    limit = tgt << 1;
    if (limit > DEPTH_C) begin
      limit = DEPTH_C;
    end

    occ_x = CW'(occ_r);
    full  = (occ_x == DEPTH_C);

    // drop one first when the ring is full
    sum_a = CW'(head_r) + CW'(full);
    if (sum_a >= DEPTH_C) begin
      sum_a = sum_a - DEPTH_C;
    end
    head1 = IDX_W'(sum_a);
    occ1  = occ_x - CW'(full);

    // write slot is head + occupancy on the original values
    sum_b = CW'(head_r) + occ_x;
    if (sum_b >= DEPTH_C) begin
      sum_b = sum_b - DEPTH_C;
    end
    wr_addr = IDX_W'(sum_b);

    occ2  = occ1 + CW'(1);
    extra = (occ2 > limit) ? (occ2 - limit) : '0;
    sum_c = CW'(head1) + extra;
    if (sum_c >= DEPTH_C) begin
      sum_c = sum_c - DEPTH_C;
    end

    expect_seq = last_r + SEQ_W'(1);
    diff       = seq_r - expect_seq;
    phase_inc  = {1'b0, phase_r} + (PHASE_W+1)'(1);
  end

  always_comb begin
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    primed_nxt = primed_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    rcv_nxt    = rcv_r;
    lost_nxt   = lost_r;
    phase_nxt  = phase_r;
    wr_en      = 1'b0;
    valid_nxt  = 1'b0;
    kind_nxt   = kind_r;
    oseq_nxt   = '0;
    opay_nxt   = '0;
    gap_nxt    = '0;
    grep_nxt   = 1'b0;
    drop_nxt   = '0;
    stats_nxt  = 1'b0;

    if (cmd.exec) begin
      unique case (act_r)
        ACT_ARRIVAL: begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_QUEUED;
          rcv_nxt   = rcv_r + COUNT_W'(1);
          if (phase_inc >= (PHASE_W+1)'(STATS_PERIOD) || rcv_nxt == '0) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc[PHASE_W-1:0];
          end
          stats_nxt = (phase_nxt == '0);
          if (!first_r && seq_r != expect_seq && diff < SEQ_W'(GAP_LIMIT)) begin
            lost_nxt = lost_r + COUNT_W'(diff);
            gap_nxt  = GAP_W'(diff);
            grep_nxt = 1'b1;
          end
          last_nxt  = seq_r;
          first_nxt = 1'b0;
          wr_en     = 1'b1;
          // occupancy after the write plus any pre-drop is occ + 1
          if (!primed_r && (occ_x + CW'(1)) >= (tgt >> 1)) begin
            primed_nxt = 1'b1;
          end
          head_nxt = IDX_W'(sum_c);
          occ_nxt  = OCC_W'(occ2 - extra);
          drop_nxt = DROP_W'(extra + CW'(full));
        end
        ACT_TICK: begin
          valid_nxt = 1'b1;
          if (!primed_r) begin
            kind_nxt = KIND_NOT_PRIMED;
          end else if (occ_r == '0) begin
            kind_nxt = KIND_UNDERRUN;
          end else begin
            kind_nxt = KIND_SAMPLES;
            oseq_nxt = rd_data_r[ENTRY_W-1:PAYLOAD_W];
            opay_nxt = rd_data_r[PAYLOAD_W-1:0];
            head_nxt = (head_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
            occ_nxt  = occ_r - OCC_W'(1);
          end
        end
        ACT_RESTART: begin
          valid_nxt  = 1'b1;
          kind_nxt   = KIND_RESTARTED;
          head_nxt   = '0;
          occ_nxt    = '0;
          primed_nxt = 1'b0;
          first_nxt  = 1'b1;
          rcv_nxt    = '0;
          lost_nxt   = '0;
          phase_nxt  = '0;
        end
        ACT_NONE: begin
          // no state change, no result
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      head_r   <= '0;
      occ_r    <= '0;
      primed_r <= 1'b0;
      first_r  <= 1'b1;
      last_r   <= '0;
      rcv_r    <= '0;
      lost_r   <= '0;
      phase_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        target_r <= cfg_target_depth;
      end
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      primed_r <= primed_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      rcv_r    <= rcv_nxt;
      lost_r   <= lost_nxt;
      phase_r  <= phase_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // result payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      kind_r  <= kind_nxt;
      oseq_r  <= oseq_nxt;
      opay_r  <= opay_nxt;
      gap_r   <= gap_nxt;
      grep_r  <= grep_nxt;
      drop_r  <= drop_nxt;
      stats_r <= stats_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_kind             = kind_r;
  assign out_seq              = oseq_r;
  assign out_payload          = opay_r;
  assign out_gap              = gap_r;
  assign out_gap_reported     = grep_r;
  assign out_dropped          = drop_r;
  assign out_stats_due        = stats_r;
  assign out_packets_received = rcv_r;
  assign out_packets_lost     = lost_r;
  assign out_buffered         = BUF_W'(occ_r);
  assign out_primed           = primed_r;

endmodule

// File: sv/audio_jitter_buffer_seq_tracker_top.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer_seq_tracker_top
// Jitter buffer with sequence-gap loss counting: arrivals, playout ticks
// and restarts in, one status item out per command except ACT_NONE.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   input     start / busy           in_action, in_seq_num, in_payload_handle
//   result    out_valid (strobe)     out_kind .. out_primed
//   config    cfg_valid / cfg_ready  cfg_target_depth
//
// Each item is first captured, which also launches the ring read at the
// head, and then executed, which updates state and writes the ring; the result strobe
// follows in the next cycle, while a new item can already be accepted.
// Reset is synchronous; no clearing pass, the ring is only read inside
// the occupied window. The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module audio_jitter_buffer_seq_tracker_top #(
  parameter int MAX_TARGET  = ajb_pkg::MAX_TARGET_DEF,
  parameter int STORE_DEPTH = ajb_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ajb_pkg::ACTION_W-1:0]  in_action,
  input  logic [ajb_pkg::SEQ_W-1:0]     in_seq_num,
  input  logic [ajb_pkg::PAYLOAD_W-1:0] in_payload_handle,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ajb_pkg::TARGET_W-1:0]  cfg_target_depth,
  output logic                          out_valid,
  output logic [ajb_pkg::KIND_W-1:0]    out_kind,
  output logic [ajb_pkg::SEQ_W-1:0]     out_seq,
  output logic [ajb_pkg::PAYLOAD_W-1:0] out_payload,
  output logic [ajb_pkg::GAP_W-1:0]     out_gap,
  output logic                          out_gap_reported,
  output logic [ajb_pkg::DROP_W-1:0]    out_dropped,
  output logic                          out_stats_due,
  output logic [ajb_pkg::COUNT_W-1:0]   out_packets_received,
  output logic [ajb_pkg::COUNT_W-1:0]   out_packets_lost,
  output logic [ajb_pkg::BUF_W-1:0]     out_buffered,
  output logic                          out_primed
);
  import ajb_pkg::*;

  ajb_cmd_t cmd;

  ajb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  ajb_datapath #(
    .MAX_TARGET  (MAX_TARGET),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_target_depth     (cfg_target_depth),
    .in_action            (in_action),
    .in_seq_num           (in_seq_num),
    .in_payload_handle    (in_payload_handle),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_seq              (out_seq),
    .out_payload          (out_payload),
    .out_gap              (out_gap),
    .out_gap_reported     (out_gap_reported),
    .out_dropped          (out_dropped),
    .out_stats_due        (out_stats_due),
    .out_packets_received (out_packets_received),
    .out_packets_lost     (out_packets_lost),
    .out_buffered         (out_buffered),
    .out_primed           (out_primed)
  );

endmodule
